// File: sv/temperature_seven_segment_formatter_unit_assert.svh
// Assertion macros shared by the temperature formatter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef TEMPERATURE_SEVEN_SEGMENT_FORMATTER_UNIT_ASSERT_SVH
`define TEMPERATURE_SEVEN_SEGMENT_FORMATTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is high
`define TSSF_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Clocked check that also holds through reset
`define TSSF_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define TSSF_ASSERT(label, clk_s, rst_s, prop, msg)
`define TSSF_ASSERT_ALWAYS(label, clk_s, prop, msg)
`endif
`endif

// File: sv/tssf_pkg.sv
// Package for the temperature formatter: widths, constants, the queue entry
// and result types, and constant-divisor helpers. No dependencies.
`timescale 1ns / 1ps

package tssf_pkg;

  // Fixed point of the incoming reading
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned TEMP_W    = 13;

  // Internal value v is in units of 1/(5 * 2^FRAC_BITS) degree
  localparam int unsigned D_VAL   = 5 << FRAC_BITS;
  localparam int unsigned V_MAX   = 9 * 4095 + (160 << FRAC_BITS);
  localparam int unsigned V_W     = $clog2(V_MAX + 1);
  localparam int unsigned VS_W    = V_W + 1;
  localparam int unsigned XF_W    = V_W + 6;
  localparam int unsigned BIG_MIN = 100 * D_VAL;

  localparam logic signed [VS_W-1:0] F_OFF = VS_W'(160 << FRAC_BITS);

  // Scaled numerators after the power-of-two part of the divide
  localparam int unsigned XT_MAX = (20 * V_MAX + D_VAL) >> (FRAC_BITS + 1);
  localparam int unsigned XT_W   = $clog2(XT_MAX + 1);
  localparam int unsigned TQ_MAX = XT_MAX / 5;
  localparam int unsigned TQ_W   = $clog2(TQ_MAX + 1);

  // Reciprocal constants: exact for every input of the given width
  localparam int unsigned D5_SH  = XT_W + 3;
  localparam int unsigned D5_M   = ((1 << D5_SH) + 4) / 5;
  localparam int unsigned D10_SH = TQ_W + 4;
  localparam int unsigned D10_M  = ((1 << D10_SH) + 9) / 10;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Display codes
  localparam logic [3:0] UNIT_C = 4'd12;
  localparam logic [3:0] UNIT_F = 4'd15;

  localparam logic [6:0] DP_LEFT_HUND  = 7'(1 << 5);
  localparam logic [6:0] DP_LEFT_FRAC  = 7'(1 << 6);
  localparam logic [6:0] DP_RIGHT_HUND = 7'(1 << 1);
  localparam logic [6:0] DP_RIGHT_FRAC = 7'(1 << 2);

  typedef struct packed {
    logic [V_W-1:0] v;
    logic           big;
    logic           fahr;
    logic           side;
  } entry_t;

  typedef struct packed {
    logic [6:0] dp_mask;
    logic       is_hundred;
    logic [3:0] unit_code;
    logic [3:0] digit_low;
    logic [3:0] digit_mid;
    logic       top_blank;
    logic [3:0] digit_top;
    logic       half;
  } result_t;

  // floor(x / 5) by reciprocal multiply
  function automatic logic [TQ_W-1:0] div5(input logic [XT_W-1:0] x);
    logic [2*XT_W:0] p;
    p = {{(XT_W+1){1'b0}}, x} * (2*XT_W+1)'(D5_M);
    return p[D5_SH +: TQ_W];
  endfunction

  // floor(x / 10) by reciprocal multiply
  function automatic logic [TQ_W-1:0] div10(input logic [TQ_W-1:0] x);
    logic [2*TQ_W:0] p;
    p = {{(TQ_W+1){1'b0}}, x} * (2*TQ_W+1)'(D10_M);
    return {3'b000, p[D10_SH +: TQ_W-3]};
  endfunction

  // x - 10 * q, given q = floor(x / 10)
  function automatic logic [3:0] rem10(input logic [TQ_W-1:0] x,
                                       input logic [TQ_W-1:0] q);
    logic [TQ_W-1:0] r;
    r = x - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction

endpackage

// File: sv/tssf_front.sv
// Front end: takes a reading, scales it to the internal unit and clamps it.
// Depends on tssf_pkg.
`timescale 1ns / 1ps

module tssf_front import tssf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [TEMP_W-1:0] temp_c,
  input  logic                     fahr,
  input  logic                     side,
  output entry_t                   ent,
  output logic                     ent_valid,
  input  logic                     ent_ready
);

  logic                   valid;
  logic                   load;
  logic signed [VS_W-1:0] ts;
  logic signed [VS_W-1:0] vs;
  logic [V_W-1:0]         v_clamp;

  assign s_tready  = !valid || ent_ready;
  assign load      = s_tvalid && s_tready;
  assign ent_valid = valid;

  // v = 9t + 160*2^F for Fahrenheit, else 5t; negative clamps to zero
  always_comb begin
    ts = VS_W'(temp_c);
    if (fahr) begin
      vs = (ts <<< 3) + ts + F_OFF;
    end else begin
      vs = (ts <<< 2) + ts;
    end
    v_clamp = vs[VS_W-1] ? '0 : vs[V_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ent_ready) begin
      valid <= 1'b0;
    end
  end

  // Classify: big picks whole-degree rounding
  always_ff @(posedge clk) begin
    if (load) begin
      ent.v    <= v_clamp;
      ent.big  <= (32'(v_clamp) >= BIG_MIN);
      ent.fahr <= fahr;
      ent.side <= side;
    end
  end

endmodule

// File: sv/tssf_queue.sv
// Short request queue between the front and back ends.
// Depends on tssf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "temperature_seven_segment_formatter_unit_assert.svh"

module tssf_queue import tssf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t in_ent,
  input  logic   in_valid,
  output logic   in_ready,
  output entry_t out_ent,
  output logic   out_valid,
  input  logic   out_ready
);

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != Q_CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign out_ent   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ent;
    end
  end

  `TSSF_ASSERT(a_q_bound, clk, rst, count <= Q_CNT_W'(Q_DEPTH), "queue overfilled")
  `TSSF_ASSERT(a_q_drain, clk, rst, pop && !push |=> count == $past(count) - 1'b1, "queue count slip")

endmodule

// File: sv/tssf_back.sv
// Back end: rounding, digit split, hundred flags and decimal-point mask.
// Depends on tssf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "temperature_seven_segment_formatter_unit_assert.svh"

module tssf_back import tssf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  entry_t  ent,
  input  logic    ent_valid,
  output logic    ent_ready,
  output result_t res,
  output logic    m_tvalid,
  input  logic    m_tready
);

  logic en;

  // Stage 1: tenths count and whole count
  logic [XF_W-1:0] xt_full;
  logic [XF_W-1:0] xw_full;
  logic [XT_W-1:0] x_t;
  logic [XT_W-1:0] x_w;
  logic            s1_valid;
  logic [TQ_W-1:0] s1_tq;
  logic [TQ_W-1:0] s1_ww;
  logic            s1_big;
  logic            s1_fahr;
  logic            s1_side;

  // Stage 2: chosen whole value, tenths digit
  logic [TQ_W-1:0] tq_q;
  logic            s2_valid;
  logic [TQ_W-1:0] s2_w;
  logic [3:0]      s2_tq_low;
  logic            s2_fahr;
  logic            s2_side;

  // Stage 3: ones digit
  logic [TQ_W-1:0] w_q;
  logic            s3_valid;
  logic [TQ_W-1:0] s3_q1;
  logic [3:0]      s3_r0;
  logic [3:0]      s3_tq_low;
  logic            s3_hund;
  logic            s3_small;
  logic            s3_fahr;
  logic            s3_side;

  // Stage 4: tens digit
  logic [TQ_W-1:0] q2;
  logic            s4_valid;
  logic [TQ_W-1:0] s4_q2;
  logic [3:0]      s4_r1;
  logic [3:0]      s4_r0;
  logic [3:0]      s4_tq_low;
  logic            s4_hund;
  logic            s4_small;
  logic            s4_fahr;
  logic            s4_side;

  // Output stage
  logic [TQ_W-1:0] q3;
  logic [3:0]      r2;
  logic            o_valid;
  logic            left_flag;
  logic            right_flag;
  logic            left_next;
  logic            right_next;

  // Whole pipeline moves together whenever the output slot is empty or being taken
  assign en        = !o_valid || m_tready;
  assign ent_ready = en;
  assign m_tvalid  = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (en) begin
      s1_valid <= ent_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      o_valid  <= s4_valid;
    end
  end

  // Round half up: (20v + D) / 2D and (2v + D) / 2D
  always_comb begin
    xt_full = ({6'b000000, ent.v} << 4) + ({6'b000000, ent.v} << 2) + XF_W'(D_VAL);
    xw_full = ({6'b000000, ent.v} << 1) + XF_W'(D_VAL);
    x_t     = XT_W'(xt_full >> (FRAC_BITS + 1));
    x_w     = XT_W'(xw_full >> (FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tq   <= div5(x_t);
      s1_ww   <= div5(x_w);
      s1_big  <= ent.big;
      s1_fahr <= ent.fahr;
      s1_side <= ent.side;
    end
  end

  // Below the hundred mark the whole value comes from the tenths count
  assign tq_q = div10(s1_tq);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w      <= s1_big ? s1_ww : tq_q;
      s2_tq_low <= rem10(s1_tq, tq_q);
      s2_fahr   <= s1_fahr;
      s2_side   <= s1_side;
    end
  end

  assign w_q = div10(s2_w);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_q1     <= w_q;
      s3_r0     <= rem10(s2_w, w_q);
      s3_tq_low <= s2_tq_low;
      s3_hund   <= (s2_w >= TQ_W'(100));
      s3_small  <= (s2_w < TQ_W'(10));
      s3_fahr   <= s2_fahr;
      s3_side   <= s2_side;
    end
  end

  assign q2 = div10(s3_q1);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_q2     <= q2;
      s4_r1     <= rem10(s3_q1, q2);
      s4_r0     <= s3_r0;
      s4_tq_low <= s3_tq_low;
      s4_hund   <= s3_hund;
      s4_small  <= s3_small;
      s4_fahr   <= s3_fahr;
      s4_side   <= s3_side;
    end
  end

  // Hundreds digit wraps modulo ten
  assign q3 = div10(s4_q2);
  assign r2 = rem10(s4_q2, q3);

  // Flag of the half written takes the new value first
  always_comb begin
    left_next  = s4_side ? s4_hund : left_flag;
    right_next = s4_side ? right_flag : s4_hund;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_flag  <= 1'b0;
      right_flag <= 1'b0;
    end else if (en && s4_valid) begin
      left_flag  <= left_next;
      right_flag <= right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid) begin
      res.half       <= s4_side;
      res.digit_top  <= s4_hund ? r2 : (s4_small ? 4'd0 : s4_r1);
      res.top_blank  <= !s4_hund && s4_small;
      res.digit_mid  <= s4_hund ? s4_r1 : s4_r0;
      res.digit_low  <= s4_hund ? s4_r0 : s4_tq_low;
      res.unit_code  <= s4_fahr ? UNIT_F : UNIT_C;
      res.is_hundred <= s4_hund;
      res.dp_mask    <= (left_next ? DP_LEFT_HUND : DP_LEFT_FRAC)
                      | (right_next ? DP_RIGHT_HUND : DP_RIGHT_FRAC);
    end
  end

  `TSSF_ASSERT(a_blank_top, clk, rst, o_valid && res.top_blank |-> res.digit_top == 4'd0 && !res.is_hundred, "blanked digit not clear")
  `TSSF_ASSERT(a_flag_echo, clk, rst, o_valid |-> (res.half ? left_flag : right_flag) == res.is_hundred, "flag disagrees with result")
  `TSSF_ASSERT(a_dp_flags, clk, rst, o_valid |-> res.dp_mask == ((left_flag ? DP_LEFT_HUND : DP_LEFT_FRAC) | (right_flag ? DP_RIGHT_HUND : DP_RIGHT_FRAC)), "decimal points disagree with flags")
  `TSSF_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !o_valid && !left_flag && !right_flag, "reset left state behind")

endmodule

// File: sv/temperature_seven_segment_formatter_unit.sv
// A request passes the front register, the queue and the back pipeline in order.
// Throughput: one request per cycle while the output is not stalled; the five-stage
// back pipeline advances as one whenever the output register is empty or taken.
// A two-entry queue lets the input keep accepting while a result is held.
// Reset (rst, synchronous): empties all stages and the queue, clears both hundred flags.
`timescale 1ns / 1ps

module temperature_seven_segment_formatter_unit import tssf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] temp_c, [15:13] zero
  input  logic [1:0]  s_tuser,   // [0] fahrenheit, [1] side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] digit_top, [4] top_blank, [8:5] digit_mid,
                                 // [12:9] digit_low, [16:13] unit_code, [17] is_hundred,
                                 // [24:18] dp_mask, [31:25] zero
  output logic        m_tuser    // [0] half
);

  logic signed [TEMP_W-1:0] temp_c;
  entry_t                   f_ent;
  logic                     f_valid;
  logic                     f_ready;
  entry_t                   q_ent;
  logic                     q_valid;
  logic                     q_ready;
  result_t                  res;

  assign temp_c = s_tdata[TEMP_W-1:0];

  tssf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .temp_c    (temp_c),
    .fahr      (s_tuser[0]),
    .side      (s_tuser[1]),
    .ent       (f_ent),
    .ent_valid (f_valid),
    .ent_ready (f_ready)
  );

  tssf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_ent    (f_ent),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_ent   (q_ent),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  tssf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (q_ent),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
  );

  // Pack the result for the output stream
  assign m_tdata = {7'b0000000, res.dp_mask, res.is_hundred, res.unit_code,
                    res.digit_low, res.digit_mid, res.top_blank, res.digit_top};
  assign m_tuser = res.half;

endmodule

// File: verif/tb_temperature_seven_segment_formatter_unit.sv
// Self-checking testbench for temperature_seven_segment_formatter_unit.
// Holds its own predictor of the digits, unit code and decimal-point flags.
// Depends on tssf_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tb_temperature_seven_segment_formatter_unit;
  import tssf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_READINGS = 1600;
  localparam int REPORT_CAP = 40;
  // one unit of the internal value is 1/(5 * 2^FRAC_BITS) degree
  localparam int DEG_DIV = 5 << FRAC_BITS;
  localparam int F_OFFSET = 160 << FRAC_BITS;

  typedef struct {
    logic [12:0] temp;
    logic        fahr;
    logic        side;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [12:0] temp_c, [15:13] zero
  logic [1:0]  s_tuser;   // [0] fahrenheit, [1] side
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [3:0] digit_top, [4] top_blank, [8:5] digit_mid,
                          // [12:9] digit_low, [16:13] unit_code, [17] is_hundred,
                          // [24:18] dp_mask, [31:25] zero
  logic        m_tuser;   // [0] half

  reading_t reading_queue[$];
  result_t  display_due[$];
  logic     left_hund;
  logic     right_hund;
  int       mismatch_count;
  int       cycle_count;
  int       src_gap;
  bit       src_calm;
  int       snk_hold;
  bit       snk_calm;
  reading_t next_reading;
  result_t  got;
  result_t  want;

  temperature_seven_segment_formatter_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // Digits and decimal points for one reading; updates the hundred flags
  function automatic result_t format_reading(logic [12:0] temp, logic fahr, logic side);
    result_t r;
    int t, v, tq, w;
    logic hund;
    t = int'($signed(temp));
    v = fahr ? 9 * t + F_OFFSET : 5 * t;
    if (v < 0) v = 0;
    tq = (20 * v + DEG_DIV) / (2 * DEG_DIV);
    // whole degrees from the value itself once at 100 or above, else from tenths
    w = (v >= 100 * DEG_DIV) ? (2 * v + DEG_DIV) / (2 * DEG_DIV) : tq / 10;
    hund = (w >= 100);
    r.half = side;
    r.is_hundred = hund;
    r.unit_code = fahr ? UNIT_F : UNIT_C;
    r.top_blank = 1'b0;
    if (hund) begin
      r.digit_top = 4'((w / 100) % 10);
      r.digit_mid = 4'((w / 10) % 10);
      r.digit_low = 4'(w % 10);
    end else begin
      r.digit_top = 4'((w / 10) % 10);
      if (w < 10) begin
        r.digit_top = 4'd0;
        r.top_blank = 1'b1;
      end
      r.digit_mid = 4'(w % 10);
      r.digit_low = 4'(tq % 10);
    end
    // flag of the written half first, then the mask from both
    if (side) left_hund = hund;
    else right_hund = hund;
    r.dp_mask = (left_hund ? DP_LEFT_HUND : DP_LEFT_FRAC)
              | (right_hund ? DP_RIGHT_HUND : DP_RIGHT_FRAC);
    return r;
  endfunction

  // Mostly no wait, some short waits, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Readings weighted towards the rounding and blanking boundaries
  function automatic logic [12:0] pick_temp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 13'($urandom);
    if (r < 68) return 13'($urandom_range(0, 1650));
    if (r < 86) begin
      case ($urandom_range(0, 4))
        0: return 13'($urandom_range(1585, 1620));   // Celsius near 100
        1: return 13'($urandom_range(596, 612));     // Fahrenheit near 100
        2: return 13'($urandom_range(150, 170));     // Celsius near 10
        3: return 13'(-$urandom_range(170, 200));    // Fahrenheit near 10
        default: return 13'(-$urandom_range(280, 290)); // Fahrenheit near 0
      endcase
    end
    return 13'(-$urandom_range(1, 4096));
  endfunction

  task automatic add_reading(int temp, bit fahr, bit side);
    reading_t rd;
    rd.temp = 13'(temp);
    rd.fahr = fahr;
    rd.side = side;
    reading_queue.push_back(rd);
  endtask

  task automatic report_mismatch(string field, int got_val, int want_val);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got_val,
               want_val);
    mismatch_count++;
  endtask

  // Request driver: one reading per handshake, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        display_due.push_back(format_reading(s_tdata[12:0], s_tuser[0], s_tuser[1]));
      if (!s_tvalid || s_tready) begin
        if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (reading_queue.size() > 0) begin
          next_reading = reading_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b000, next_reading.temp};
          s_tuser <= {next_reading.side, next_reading.fahr};
          src_gap = src_calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and sink stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.half       = m_tuser;
        got.digit_top  = m_tdata[3:0];
        got.top_blank  = m_tdata[4];
        got.digit_mid  = m_tdata[8:5];
        got.digit_low  = m_tdata[12:9];
        got.unit_code  = m_tdata[16:13];
        got.is_hundred = m_tdata[17];
        got.dp_mask    = m_tdata[24:18];
        if (display_due.size() == 0) begin
          report_mismatch("result with none outstanding", 1, 0);
        end else begin
          want = display_due.pop_front();
          if (got.half !== want.half) report_mismatch("half", got.half, want.half);
          if (got.digit_top !== want.digit_top)
            report_mismatch("digit_top", got.digit_top, want.digit_top);
          if (got.top_blank !== want.top_blank)
            report_mismatch("top_blank", got.top_blank, want.top_blank);
          if (got.digit_mid !== want.digit_mid)
            report_mismatch("digit_mid", got.digit_mid, want.digit_mid);
          if (got.digit_low !== want.digit_low)
            report_mismatch("digit_low", got.digit_low, want.digit_low);
          if (got.unit_code !== want.unit_code)
            report_mismatch("unit_code", got.unit_code, want.unit_code);
          if (got.is_hundred !== want.is_hundred)
            report_mismatch("is_hundred", got.is_hundred, want.is_hundred);
          if (got.dp_mask !== want.dp_mask)
            report_mismatch("dp_mask", got.dp_mask, want.dp_mask);
        end
      end
      if ($urandom_range(0, 199) == 0) snk_calm = !snk_calm;
      if (snk_hold > 0) begin
        snk_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!snk_calm && $urandom_range(0, 99) < 20) snk_hold = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL temperature_seven_segment_formatter_unit");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    left_hund = 1'b0;
    right_hund = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    src_calm = 1'b0;
    snk_calm = 1'b0;

    // Directed: field extremes, clamping, blanking, rounding edges, both halves
    add_reading(-4096, 0, 0);
    add_reading(4095, 0, 1);
    add_reading(-4096, 1, 1);
    add_reading(4095, 1, 0);
    add_reading(0, 0, 0);
    add_reading(0, 1, 1);
    add_reading(-1, 0, 0);
    add_reading(1, 0, 1);
    add_reading(4, 0, 0);       // 0.25, exactly halfway between tenths, rounds up
    add_reading(159, 0, 0);     // 9.9, tens blanked
    add_reading(160, 0, 1);     // 10.0, tens shown
    add_reading(1599, 0, 1);    // 99.9
    add_reading(604, 1, 1);     // just under 100 F, rounds up to hundred
    add_reading(1600, 0, 0);
    add_reading(1608, 0, 0);    // 100.5 rounds to 101
    add_reading(1607, 0, 1);
    add_reading(-284, 1, 0);    // just above 0 F
    add_reading(-285, 1, 1);    // just below 0 F, clamped
    add_reading(1, 1, 0);
    add_reading(-2048, 0, 1);
    add_reading(2047, 1, 0);

    repeat (RANDOM_READINGS) add_reading(pick_temp(), $urandom_range(0, 1),
                                         $urandom_range(0, 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests sent and every result back, then a little extra;
    // looked at on the falling edge so the driver and monitor have settled
    do @(negedge clk);
    while (reading_queue.size() > 0 || s_tvalid || display_due.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS temperature_seven_segment_formatter_unit");
    end else begin
      $display("FAIL temperature_seven_segment_formatter_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/tssf_pkg.sv
sv/tssf_front.sv
sv/tssf_queue.sv
sv/tssf_back.sv
sv/temperature_seven_segment_formatter_unit.sv
verif/tb_temperature_seven_segment_formatter_unit.sv
